### sv/bcsc_pkg.sv
// Shared types, constants and helpers of the battery charge stage controller.
// No dependencies; every other file refers to it by scoped names.
package bcsc_pkg;

  localparam int ADC_BITS_DEF  = 12;
  localparam int TICK_BITS_DEF = 32;

  // Configuration port and register storage widths
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int LVL_BITS      = 16;
  localparam int TIMEOUT_BITS  = 32;
  localparam int DLY_BITS      = 16;

  localparam int STAGE_BITS = 3;
  localparam int DRIVE_BITS = 7;
  localparam int SETTLE_BITS = 5;
  localparam int TEMP_BITS  = 3;

  // Register reset values
  localparam int LOW_CAP_RESET   = 2000;
  localparam int PRECHARGE_RESET = 2500;
  localparam int FULL_RESET      = 3500;
  localparam int RECHARGE_RESET  = 3300;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(600000);
  localparam logic [DLY_BITS-1:0] FAST_DLY_RESET = DLY_BITS'(500);
  localparam logic [DLY_BITS-1:0] SLOW_DLY_RESET = DLY_BITS'(100);
  localparam int MARGIN_RESET    = 500;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_LOW_CAP   = 3'd0,
    REG_PRECHARGE = 3'd1,
    REG_FULL      = 3'd2,
    REG_RECHARGE  = 3'd3,
    REG_TIMEOUT   = 3'd4,
    REG_FAST_DLY  = 3'd5,
    REG_SLOW_DLY  = 3'd6,
    REG_MARGIN    = 3'd7
  } bcsc_reg_t;

  typedef enum logic [4:0] {
    ST_LOW  = 5'b00001,
    ST_PRE  = 5'b00010,
    ST_CC   = 5'b00100,
    ST_RC   = 5'b01000,
    ST_TERM = 5'b10000
  } bcsc_stage_t;

  // External stage codes
  localparam logic [STAGE_BITS-1:0] CODE_LOW  = 3'd0;
  localparam logic [STAGE_BITS-1:0] CODE_PRE  = 3'd1;
  localparam logic [STAGE_BITS-1:0] CODE_CC   = 3'd2;
  localparam logic [STAGE_BITS-1:0] CODE_RC   = 3'd3;
  localparam logic [STAGE_BITS-1:0] CODE_TERM = 3'd4;

  localparam logic [DRIVE_BITS-1:0] DRIVE_OFF  = 7'd0;
  localparam logic [DRIVE_BITS-1:0] DRIVE_SOFT = 7'd20;
  localparam logic [DRIVE_BITS-1:0] DRIVE_PRE  = 7'd40;
  localparam logic [DRIVE_BITS-1:0] DRIVE_RC   = 7'd50;
  localparam logic [DRIVE_BITS-1:0] DRIVE_FULL = 7'd100;

  localparam logic [SETTLE_BITS-1:0] SETTLE_NONE  = 5'd0;
  localparam logic [SETTLE_BITS-1:0] SETTLE_SHORT = 5'd2;
  localparam logic [SETTLE_BITS-1:0] SETTLE_LONG  = 5'd20;

  localparam logic [TEMP_BITS-1:0] TEMP_ABSENT  = 3'd0;
  localparam logic [TEMP_BITS-1:0] TEMP_EXTREME = 3'd5;

  typedef struct packed {
    logic fast;
    logic full;
    logic disc;
    logic fail;
  } bcsc_leds_t;

  typedef struct packed {
    logic [LVL_BITS-1:0]     low_cap;
    logic [LVL_BITS-1:0]     precharge;
    logic [LVL_BITS-1:0]     full;
    logic [LVL_BITS-1:0]     recharge;
    logic [TIMEOUT_BITS-1:0] timeout;
    logic [DLY_BITS-1:0]     fast_dly;
    logic [DLY_BITS-1:0]     slow_dly;
    logic [LVL_BITS-1:0]     margin;
  } bcsc_cfg_t;

  function automatic logic [STAGE_BITS-1:0] stage_code(bcsc_stage_t st);
    logic [STAGE_BITS-1:0] code;
    unique case (st)
      ST_LOW:  code = CODE_LOW;
      ST_PRE:  code = CODE_PRE;
      ST_CC:   code = CODE_CC;
      ST_RC:   code = CODE_RC;
      ST_TERM: code = CODE_TERM;
      default: code = CODE_LOW;
    endcase
    return code;
  endfunction

endpackage

### sv/bcsc_sample_if.sv
// Sample channel of the battery charge stage controller.
// Depends on bcsc_pkg for default widths.
interface bcsc_sample_if #(
  parameter int ADC_BITS  = bcsc_pkg::ADC_BITS_DEF,
  parameter int TICK_BITS = bcsc_pkg::TICK_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [ADC_BITS-1:0]            battery_reading;
  logic [ADC_BITS-1:0]            charger_reading;
  logic [bcsc_pkg::TEMP_BITS-1:0] bottom_temp_code;
  logic [bcsc_pkg::TEMP_BITS-1:0] top_temp_code;
  logic                           in_standby;
  logic [TICK_BITS-1:0]           now_ms;

  modport source (
    output valid, battery_reading, charger_reading, bottom_temp_code, top_temp_code,
           in_standby, now_ms,
    input  ready
  );
  modport sink (
    input  valid, battery_reading, charger_reading, bottom_temp_code, top_temp_code,
           in_standby, now_ms,
    output ready
  );
endinterface

### sv/bcsc_result_if.sv
// Result channel of the battery charge stage controller.
// Depends on bcsc_pkg for field widths.
interface bcsc_result_if;
  logic                             valid;
  logic                             ready;
  logic [bcsc_pkg::STAGE_BITS-1:0]  charge_stage;
  logic [bcsc_pkg::DRIVE_BITS-1:0]  drive_percent;
  logic                             fast_charge_led;
  logic                             full_float_led;
  logic                             disconnect_led;
  logic                             charger_fail_led;
  logic [bcsc_pkg::SETTLE_BITS-1:0] settle_delay_ms;

  modport source (
    output valid, charge_stage, drive_percent, fast_charge_led, full_float_led,
           disconnect_led, charger_fail_led, settle_delay_ms,
    input  ready
  );
  modport sink (
    input  valid, charge_stage, drive_percent, fast_charge_led, full_float_led,
           disconnect_led, charger_fail_led, settle_delay_ms,
    output ready
  );
endinterface

### sv/bcsc_cfg_if.sv
// Register write channel of the battery charge stage controller.
// Depends on bcsc_pkg for index and data widths.
interface bcsc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bcsc_pkg::CFG_ADDR_BITS-1:0] index;
  logic [bcsc_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/battery_charge_stage_controller.sv
// Battery charge stage controller: takes one sample beat per clock unless the result side
// stalls, and returns one result beat per sample. A sample is held in an input register; once
// the result register can load, the stage logic updates the kept stage, stage start time, drive
// and LEDs and loads the result register, so the sustained rate is one sample per cycle while
// the result side keeps taking beats. The input register frees as soon as the result register
// can load, so a new sample is taken even while a finished result waits. Register writes are
// meant for idle periods only.
// Depends on bcsc_pkg, the three channel interfaces, bcsc_cfg and bcsc_step.
module battery_charge_stage_controller #(
  parameter int ADC_BITS  = bcsc_pkg::ADC_BITS_DEF,
  parameter int TICK_BITS = bcsc_pkg::TICK_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  bcsc_sample_if.sink     samp,
  bcsc_result_if.source   res,
  bcsc_cfg_if.sink        cfg
);

  bcsc_pkg::bcsc_cfg_t regs;

  // input register
  logic                           pipe_valid;
  logic [ADC_BITS-1:0]            pipe_batt;
  logic [ADC_BITS-1:0]            pipe_chg;
  logic [bcsc_pkg::TEMP_BITS-1:0] pipe_bot;
  logic [bcsc_pkg::TEMP_BITS-1:0] pipe_top;
  logic                           pipe_standby;
  logic [TICK_BITS-1:0]           pipe_now;

  // kept charger state
  bcsc_pkg::bcsc_stage_t           stage;
  logic [TICK_BITS-1:0]            stage_start;
  logic [bcsc_pkg::DRIVE_BITS-1:0] drive;
  bcsc_pkg::bcsc_leds_t            leds;

  bcsc_pkg::bcsc_stage_t            stage_next;
  logic [TICK_BITS-1:0]             stage_start_next;
  logic [bcsc_pkg::DRIVE_BITS-1:0]  drive_next;
  bcsc_pkg::bcsc_leds_t             leds_next;
  logic [bcsc_pkg::SETTLE_BITS-1:0] settle_next;

  logic res_valid;
  logic res_free;
  logic advance;

  assign res_free   = !res_valid || res.ready;
  assign advance    = pipe_valid && res_free;
  assign samp.ready = !pipe_valid || res_free;

  bcsc_cfg #(
    .ADC_BITS(ADC_BITS)
  ) u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bcsc_step #(
    .ADC_BITS (ADC_BITS),
    .TICK_BITS(TICK_BITS)
  ) u_step (
    .regs      (regs),
    .batt      (pipe_batt),
    .chg       (pipe_chg),
    .bot       (pipe_bot),
    .top       (pipe_top),
    .standby   (pipe_standby),
    .now       (pipe_now),
    .stage     (stage),
    .start     (stage_start),
    .drive     (drive),
    .leds      (leds),
    .stage_next(stage_next),
    .start_next(stage_start_next),
    .drive_next(drive_next),
    .leds_next (leds_next),
    .settle    (settle_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (samp.ready) begin
      pipe_valid <= samp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samp.valid && samp.ready) begin
      pipe_batt    <= samp.battery_reading;
      pipe_chg     <= samp.charger_reading;
      pipe_bot     <= samp.bottom_temp_code;
      pipe_top     <= samp.top_temp_code;
      pipe_standby <= samp.in_standby;
      pipe_now     <= samp.now_ms;
    end
  end

  // commit the step only when the result register takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= bcsc_pkg::ST_LOW;
      stage_start <= '0;
      drive       <= bcsc_pkg::DRIVE_OFF;
      leds        <= '0;
    end else if (advance) begin
      stage       <= stage_next;
      stage_start <= stage_start_next;
      drive       <= drive_next;
      leds        <= leds_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.charge_stage     <= bcsc_pkg::stage_code(stage_next);
      res.drive_percent    <= drive_next;
      res.fast_charge_led  <= leds_next.fast;
      res.full_float_led   <= leds_next.full;
      res.disconnect_led   <= leds_next.disc;
      res.charger_fail_led <= leds_next.fail;
      res.settle_delay_ms  <= settle_next;
    end
  end

  assign res.valid = res_valid;

  // termination always leaves the drive off
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.charge_stage == bcsc_pkg::CODE_TERM)
      |-> (res.drive_percent == bcsc_pkg::DRIVE_OFF))
    else $error("termination result with drive on");

  // a long settle request only comes with the drive cut in the low-battery stage
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.settle_delay_ms == bcsc_pkg::SETTLE_LONG)
      |-> (res.drive_percent == bcsc_pkg::DRIVE_OFF
           && res.charge_stage == bcsc_pkg::CODE_LOW))
    else $error("long settle without drive cut");

  // a sample that moves on always lands in the result register
  assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("sample lost between input and result register");

  // the kept stage only changes when a sample moves on
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(stage))
    else $error("stage changed without a sample");

endmodule

### sv/bcsc_cfg.sv
// Configuration register bank: thresholds, timeout, fast and slow check delays and margin.
// Depends on bcsc_pkg and bcsc_cfg_if.
module bcsc_cfg #(
  parameter int ADC_BITS = bcsc_pkg::ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  bcsc_cfg_if.sink            cfg,
  output bcsc_pkg::bcsc_cfg_t regs
);

  localparam logic [ADC_BITS-1:0] RST_LOW_CAP   = ADC_BITS'(bcsc_pkg::LOW_CAP_RESET);
  localparam logic [ADC_BITS-1:0] RST_PRECHARGE = ADC_BITS'(bcsc_pkg::PRECHARGE_RESET);
  localparam logic [ADC_BITS-1:0] RST_FULL      = ADC_BITS'(bcsc_pkg::FULL_RESET);
  localparam logic [ADC_BITS-1:0] RST_RECHARGE  = ADC_BITS'(bcsc_pkg::RECHARGE_RESET);
  localparam logic [ADC_BITS-1:0] RST_MARGIN    = ADC_BITS'(bcsc_pkg::MARGIN_RESET);

  logic [bcsc_pkg::LVL_BITS-1:0] wr_lvl;

  assign cfg.ready = 1'b1;
  assign wr_lvl = bcsc_pkg::LVL_BITS'(cfg.data[ADC_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_cap   <= bcsc_pkg::LVL_BITS'(RST_LOW_CAP);
      regs.precharge <= bcsc_pkg::LVL_BITS'(RST_PRECHARGE);
      regs.full      <= bcsc_pkg::LVL_BITS'(RST_FULL);
      regs.recharge  <= bcsc_pkg::LVL_BITS'(RST_RECHARGE);
      regs.timeout   <= bcsc_pkg::TIMEOUT_RESET;
      regs.fast_dly  <= bcsc_pkg::FAST_DLY_RESET;
      regs.slow_dly  <= bcsc_pkg::SLOW_DLY_RESET;
      regs.margin    <= bcsc_pkg::LVL_BITS'(RST_MARGIN);
    end else if (cfg.valid) begin
      unique case (bcsc_pkg::bcsc_reg_t'(cfg.index))
        bcsc_pkg::REG_LOW_CAP:   regs.low_cap   <= wr_lvl;
        bcsc_pkg::REG_PRECHARGE: regs.precharge <= wr_lvl;
        bcsc_pkg::REG_FULL:      regs.full      <= wr_lvl;
        bcsc_pkg::REG_RECHARGE:  regs.recharge  <= wr_lvl;
        bcsc_pkg::REG_TIMEOUT:   regs.timeout   <= cfg.data[bcsc_pkg::TIMEOUT_BITS-1:0];
        bcsc_pkg::REG_FAST_DLY:  regs.fast_dly  <= cfg.data[bcsc_pkg::DLY_BITS-1:0];
        bcsc_pkg::REG_SLOW_DLY:  regs.slow_dly  <= cfg.data[bcsc_pkg::DLY_BITS-1:0];
        bcsc_pkg::REG_MARGIN:    regs.margin    <= wr_lvl;
        default: ;
      endcase
    end
  end

endmodule

### sv/bcsc_step.sv
// Next-state logic for one sample: stage transitions, drive, LEDs and settle delay.
// Depends on bcsc_pkg; purely combinational.
module bcsc_step #(
  parameter int ADC_BITS  = bcsc_pkg::ADC_BITS_DEF,
  parameter int TICK_BITS = bcsc_pkg::TICK_BITS_DEF
) (
  input  bcsc_pkg::bcsc_cfg_t              regs,
  input  logic [ADC_BITS-1:0]              batt,
  input  logic [ADC_BITS-1:0]              chg,
  input  logic [bcsc_pkg::TEMP_BITS-1:0]   bot,
  input  logic [bcsc_pkg::TEMP_BITS-1:0]   top,
  input  logic                             standby,
  input  logic [TICK_BITS-1:0]             now,
  input  bcsc_pkg::bcsc_stage_t            stage,
  input  logic [TICK_BITS-1:0]             start,
  input  logic [bcsc_pkg::DRIVE_BITS-1:0]  drive,
  input  bcsc_pkg::bcsc_leds_t             leds,
  output bcsc_pkg::bcsc_stage_t            stage_next,
  output logic [TICK_BITS-1:0]             start_next,
  output logic [bcsc_pkg::DRIVE_BITS-1:0]  drive_next,
  output bcsc_pkg::bcsc_leds_t             leds_next,
  output logic [bcsc_pkg::SETTLE_BITS-1:0] settle
);

  localparam int CMP_BITS = (TICK_BITS > bcsc_pkg::TIMEOUT_BITS) ? TICK_BITS
                                                                 : bcsc_pkg::TIMEOUT_BITS;

  logic [TICK_BITS-1:0]          elapsed;
  logic [CMP_BITS-1:0]           elapsed_w;
  logic [bcsc_pkg::LVL_BITS-1:0] batt_l;
  logic [bcsc_pkg::LVL_BITS-1:0] chg_l;
  logic [bcsc_pkg::LVL_BITS-1:0] floor_lvl;
  logic                          absent;
  logic                          forced;
  logic                          supply_fail;
  logic                          timed_out;
  logic                          fast_due;
  logic                          slow_due;

  always_comb begin
    elapsed   = now - start;
    elapsed_w = CMP_BITS'(elapsed);
    batt_l    = bcsc_pkg::LVL_BITS'(batt);
    chg_l     = bcsc_pkg::LVL_BITS'(chg);
    // saturate the margin subtraction at zero
    floor_lvl = (batt_l > regs.margin) ? batt_l - regs.margin : '0;
    supply_fail = (chg_l < regs.full) && (chg_l < floor_lvl);
    timed_out = elapsed_w >= CMP_BITS'(regs.timeout);
    fast_due  = elapsed_w >= CMP_BITS'(regs.fast_dly);
    slow_due  = elapsed_w >= CMP_BITS'(regs.slow_dly);
    absent = (bot == bcsc_pkg::TEMP_ABSENT) && (top == bcsc_pkg::TEMP_ABSENT);
    forced = !standby || (bot == bcsc_pkg::TEMP_EXTREME) || (top == bcsc_pkg::TEMP_EXTREME);
  end

  always_comb begin
    stage_next = stage;
    start_next = start;
    drive_next = drive;
    leds_next  = leds;
    settle     = bcsc_pkg::SETTLE_NONE;
    if (absent) begin
      drive_next     = bcsc_pkg::DRIVE_OFF;
      settle         = bcsc_pkg::SETTLE_LONG;
      leds_next.fast = 1'b0;
      leds_next.full = 1'b0;
      leds_next.disc = 1'b1;
      stage_next     = bcsc_pkg::ST_LOW;
    end else if (forced) begin
      drive_next     = bcsc_pkg::DRIVE_OFF;
      settle         = bcsc_pkg::SETTLE_LONG;
      leds_next.fast = 1'b0;
      leds_next.full = 1'b0;
      stage_next     = bcsc_pkg::ST_LOW;
      start_next     = now;
    end else begin
      unique case (stage)
        bcsc_pkg::ST_LOW: begin
          if (batt_l <= regs.low_cap) begin
            if (!timed_out) begin
              drive_next = bcsc_pkg::DRIVE_PRE;
            end else begin
              drive_next     = bcsc_pkg::DRIVE_OFF;
              leds_next.disc = 1'b1;
            end
          end else begin
            drive_next     = bcsc_pkg::DRIVE_PRE;
            leds_next.disc = 1'b0;
            leds_next.fast = 1'b1;
            stage_next     = bcsc_pkg::ST_PRE;
            start_next     = now;
          end
        end
        bcsc_pkg::ST_PRE: begin
          if (batt_l >= regs.precharge) begin
            drive_next     = bcsc_pkg::DRIVE_FULL;
            leds_next.fast = 1'b1;
            stage_next     = bcsc_pkg::ST_CC;
            start_next     = now;
          end else if (batt_l < regs.low_cap) begin
            drive_next     = bcsc_pkg::DRIVE_OFF;
            settle         = bcsc_pkg::SETTLE_LONG;
            leds_next.fast = 1'b0;
            leds_next.disc = 1'b1;
            stage_next     = bcsc_pkg::ST_LOW;
            start_next     = now;
          end else if (fast_due) begin
            leds_next.fail = supply_fail;
          end
        end
        bcsc_pkg::ST_CC: begin
          if (batt_l >= regs.full) begin
            drive_next     = bcsc_pkg::DRIVE_OFF;
            leds_next.fast = 1'b0;
            leds_next.full = 1'b1;
            stage_next     = bcsc_pkg::ST_TERM;
            start_next     = now;
          end else if (batt_l <= regs.precharge) begin
            drive_next     = bcsc_pkg::DRIVE_SOFT;
            leds_next.fast = 1'b0;
            stage_next     = bcsc_pkg::ST_PRE;
            start_next     = now;
          end else if (fast_due) begin
            leds_next.fail = supply_fail;
          end
        end
        bcsc_pkg::ST_RC: begin
          if (batt_l >= regs.full) begin
            drive_next     = bcsc_pkg::DRIVE_OFF;
            leds_next.full = 1'b1;
            stage_next     = bcsc_pkg::ST_TERM;
            start_next     = now;
          end else if (batt_l <= regs.recharge) begin
            drive_next     = bcsc_pkg::DRIVE_FULL;
            settle         = bcsc_pkg::SETTLE_SHORT;
            leds_next.fast = 1'b1;
            leds_next.full = 1'b0;
            stage_next     = bcsc_pkg::ST_CC;
            start_next     = now;
          end else if (slow_due) begin
            leds_next.fail = chg_l < batt_l;
          end
        end
        bcsc_pkg::ST_TERM: begin
          // keep the start time on the way back to recharge
          if (slow_due && (batt_l < regs.recharge)) begin
            drive_next = bcsc_pkg::DRIVE_RC;
            settle     = bcsc_pkg::SETTLE_SHORT;
            stage_next = bcsc_pkg::ST_RC;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
